/* rtl/quaternion_to_euler_angles_macros.svh */
// Assertion macros for the quaternion to Euler angle converter.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked outside reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* rtl/qte_pkg.sv */
// Shared types, widths and constants of the quaternion to Euler angle converter.
// No dependencies; every module file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANG_TABLE_LEN     = 24;

  localparam int QW   = 16;  // input component width, Q1.15
  localparam int PW   = 32;  // exact product width, Q2.30
  localparam int NW   = 34;  // numerator and denominator width
  localparam int SW   = 32;  // clamped sine width
  localparam int VW   = 62;  // square root radicand and work width
  localparam int RTW  = 31;  // square root result width
  localparam int ISQ_STAGES = 31;
  localparam int CW   = 38;  // CORDIC vector width, covers the gain growth
  localparam int AW   = 32;  // angle accumulator width, 2^32 is a full turn

  localparam logic signed [NW-1:0] ONE_Q30     = NW'(64'sd1073741824);
  localparam logic signed [NW-1:0] NEG_ONE_Q30 = -ONE_Q30;
  localparam logic [VW-1:0]        ONE_Q60     = VW'(64'd1 << 60);

  localparam logic [AW-1:0] ACC_QUARTER     = 32'h4000_0000;
  localparam logic [AW-1:0] ACC_NEG_QUARTER = 32'hC000_0000;
  localparam logic [AW-1:0] ACC_ROUND_HALF  = 32'h0000_8000;

  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

  typedef struct packed {
    logic signed [QW-1:0] qw;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } out_beat_t;

  typedef struct packed {
    logic signed [NW-1:0] rn;
    logic signed [NW-1:0] rd;
    logic signed [NW-1:0] yn;
    logic signed [NW-1:0] yd;
    logic signed [SW-1:0] s;
  } side_t;

  typedef struct packed {
    logic [VW-1:0] v;
    side_t         side;
    logic          clamped;
  } front_t;

  // atan(2^-i) scaled so that 2^32 is a full turn.
  function automatic logic [AW-1:0] atan_step(input int i);
    logic [AW-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/qte_front.sv */
// Front end: exact Q2.30 products, atan2 operands, clamped sine and sqrt radicand.
// Four register stages. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qte_front (
  input  logic              clk,
  input  logic              en,
  input  qte_pkg::in_beat_t q,
  output qte_pkg::front_t   f
);

  localparam int PW = qte_pkg::PW;
  localparam int NW = qte_pkg::NW;
  localparam int SW = qte_pkg::SW;
  localparam int VW = qte_pkg::VW;

  // Stage A: products.
  logic signed [PW-1:0] pwx, pyz, pwz, pxy, pwy, pxz, pxx, pyy, pzz;
  // Stage B: operands and clamped sine.
  qte_pkg::side_t sideb;
  logic           clb;
  // Stage C: sine squared.
  qte_pkg::side_t sidec;
  logic           clc;
  logic [VW-1:0]  sqc;

  logic signed [NW-1:0] sraw;
  logic signed [63:0]   sprod;

  always_ff @(posedge clk) begin
    if (en) begin
      pwx <= q.qw * q.qx;
      pyz <= q.qy * q.qz;
      pwz <= q.qw * q.qz;
      pxy <= q.qx * q.qy;
      pwy <= q.qw * q.qy;
      pxz <= q.qx * q.qz;
      pxx <= q.qx * q.qx;
      pyy <= q.qy * q.qy;
      pzz <= q.qz * q.qz;
    end
  end

  assign sraw = (NW'(pwy) - NW'(pxz)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      sideb.rn <= (NW'(pwx) + NW'(pyz)) <<< 1;
      sideb.rd <= qte_pkg::ONE_Q30 - ((NW'(pxx) + NW'(pyy)) <<< 1);
      sideb.yn <= (NW'(pwz) + NW'(pxy)) <<< 1;
      sideb.yd <= qte_pkg::ONE_Q30 - ((NW'(pyy) + NW'(pzz)) <<< 1);
      if (sraw > qte_pkg::ONE_Q30) begin
        sideb.s <= SW'(qte_pkg::ONE_Q30);
        clb     <= 1'b1;
      end else if (sraw < qte_pkg::NEG_ONE_Q30) begin
        sideb.s <= SW'(qte_pkg::NEG_ONE_Q30);
        clb     <= 1'b1;
      end else begin
        sideb.s <= SW'(sraw);
        clb     <= 1'b0;
      end
    end
  end

  assign sprod = sideb.s * sideb.s;

  always_ff @(posedge clk) begin
    if (en) begin
      sqc   <= sprod[VW-1:0];
      sidec <= sideb;
      clc   <= clb;
      f.v       <= qte_pkg::ONE_Q60 - sqc;
      f.side    <= sidec;
      f.clamped <= clc;
    end
  end

endmodule

`default_nettype wire

/* rtl/qte_isqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qte_isqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qte_pkg::VW-1:0]    v,
  output logic [qte_pkg::RTW-1:0]   root
);

  localparam int VW = qte_pkg::VW;
  localparam int N  = qte_pkg::ISQ_STAGES;

  logic [VW-1:0] vs [0:N-1];
  logic [VW-1:0] rs [0:N];

  assign vs[0] = v;
  assign rs[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int B = 2 * (N - 1 - i);
    logic [VW-1:0] trial;
    logic          take;
    assign trial = rs[i] + (VW'(1) << B);
    assign take  = (vs[i] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rs[i+1] <= take ? ((rs[i] >> 1) + (VW'(1) << B)) : (rs[i] >> 1);
      end
    end

    if (i < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          vs[i+1] <= take ? (vs[i] - trial) : vs[i];
        end
      end
    end
  end

  assign root = rs[N][qte_pkg::RTW-1:0];

endmodule

`default_nettype wire

/* rtl/qte_cordic.sv */
// Pipelined vectoring CORDIC atan2 with a 16-bit rounded binary angle result.
// Pre-rotation register, iteration stages, then a rounding output register. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [qte_pkg::NW-1:0] y,
  input  logic signed [qte_pkg::NW-1:0] x,
  output logic signed [15:0]          angle
);

  localparam int CW = qte_pkg::CW;
  localparam int AW = qte_pkg::AW;

  logic signed [CW-1:0] xs  [0:STAGES-1];
  logic signed [CW-1:0] ys  [0:STAGES-1];
  logic [AW-1:0]        acc [0:STAGES];
  logic                 zf  [0:STAGES];

  logic signed [CW-1:0] xe, ye;
  logic [AW-1:0]        rnd;

  assign xe = CW'(x);
  assign ye = CW'(y);

  // Quadrant pre-rotation brings the vector into the right half plane.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          xs[0]  <= ye;
          ys[0]  <= -xe;
          acc[0] <= qte_pkg::ACC_QUARTER;
        end else begin
          xs[0]  <= -ye;
          ys[0]  <= xe;
          acc[0] <= qte_pkg::ACC_NEG_QUARTER;
        end
      end else begin
        xs[0]  <= xe;
        ys[0]  <= ye;
        acc[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [AW-1:0] STEP = qte_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1]  <= zf[i];
        acc[i+1] <= (ys[i] >= 0) ? (acc[i] + STEP) : (acc[i] - STEP);
      end
    end
    if (i < STAGES - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          if (ys[i] >= 0) begin
            xs[i+1] <= xs[i] + (ys[i] >>> i);
            ys[i+1] <= ys[i] - (xs[i] >>> i);
          end else begin
            xs[i+1] <= xs[i] - (ys[i] >>> i);
            ys[i+1] <= ys[i] + (xs[i] >>> i);
          end
        end
      end
    end
  end

  assign rnd = acc[STAGES] + qte_pkg::ACC_ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[STAGES] ? '0 : $signed(rnd[AW-1:AW-16]);
    end
  end

endmodule

`default_nettype wire

/* rtl/quaternion_to_euler_angles.sv */
// Quaternion (Q1.15) to ZYX Euler angles (16-bit binary angles), fully pipelined.
// Stages in order: front end, square root (one stage per bit), the three CORDIC units side
// by side, then the output register. Throughput: one beat per cycle while the skid is
// empty; a two-entry output register and skid keep input open until the skid fills.
// Reset (rst, synchronous) clears the pipeline valid bits and the output and skid valid
// flags; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_ready,
  input  qte_pkg::in_beat_t  quat,
  output logic               angle_valid,
  input  logic               angle_ready,
  output qte_pkg::out_beat_t angle
);

  localparam int NW      = qte_pkg::NW;
  localparam int RTW     = qte_pkg::RTW;
  localparam int ISQ     = qte_pkg::ISQ_STAGES;
  localparam int FRONT   = 4;
  localparam int COR_LAT = CORDIC_STAGES + 2;
  localparam int TOTAL   = FRONT + ISQ + COR_LAT;
  localparam int CL_LEN  = ISQ + COR_LAT;

  // The whole pipeline moves as one on en. It only halts when the skid register
  // is occupied, which happens only after the output register has been refused.
  logic                en;
  logic [TOTAL-1:0]    vp;
  logic                push;

  qte_pkg::front_t     f;
  logic [RTW-1:0]      root;
  qte_pkg::side_t      sd [0:ISQ-1];
  logic                cl [0:CL_LEN-1];

  logic signed [15:0]  ya, pa, ra, psat;
  qte_pkg::out_beat_t  pd;

  logic                ov, sv;
  qte_pkg::out_beat_t  od, skd;

  assign en         = !sv;
  assign quat_ready = en;
  assign push       = en && vp[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[TOTAL-2:0], quat_valid};
    end
  end

  qte_front u_front (
    .clk (clk),
    .en  (en),
    .q   (quat),
    .f   (f)
  );

  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v    (f.v),
    .root (root)
  );

  // Operands wait alongside the square root; the clamp flag waits through it all.
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= f.side;
      cl[0] <= f.clamped;
      for (int i = 1; i < ISQ; i++) begin
        sd[i] <= sd[i-1];
      end
      for (int i = 1; i < CL_LEN; i++) begin
        cl[i] <= cl[i-1];
      end
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y     (sd[ISQ-1].yn),
    .x     (sd[ISQ-1].yd),
    .angle (ya)
  );

  // Pitch is asin(s) taken as atan2(s, sqrt(1 - s^2)).
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y     (NW'(sd[ISQ-1].s)),
    .x     ($signed({{(NW-RTW){1'b0}}, root})),
    .angle (pa)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .en    (en),
    .y     (sd[ISQ-1].rn),
    .x     (sd[ISQ-1].rd),
    .angle (ra)
  );

  // Rounding can land pitch one step past a quarter turn; hold it to the range.
  always_comb begin
    if (pa > qte_pkg::PITCH_MAX) begin
      psat = qte_pkg::PITCH_MAX;
    end else if (pa < qte_pkg::PITCH_MIN) begin
      psat = qte_pkg::PITCH_MIN;
    end else begin
      psat = pa;
    end
    pd.yaw     = ya;
    pd.pitch   = psat;
    pd.roll    = ra;
    pd.clamped = cl[CL_LEN-1];
  end

  // Output register with a skid entry. A beat leaving the pipeline while the
  // output register is held parks in the skid, and the pipeline halts next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || angle_ready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || angle_ready) begin
      od <= sv ? skd : pd;
    end else if (push) begin
      skd <= pd;
    end
  end

  assign angle_valid = ov;
  assign angle       = od;

  `QTE_ASSERT_IMP(a_skid_needs_out, sv, ov)
  `QTE_ASSERT_NEXT(a_halt_freezes, !en, $stable(vp))
  `QTE_ASSERT_IMP(a_skid_fill_cause, $rose(sv), $past(ov && !angle_ready && push))

endmodule

`default_nettype wire
